// ===== hw/rtl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants for the day count to date converter
// Holds the sequencer state type, the day counts of the calendar chunks
// and the month length lookup.
// ----------------------------------------------------------------------------
package dcc_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFS,
    S_DIV,
    S_C100,
    S_C4,
    S_Y1,
    S_MON,
    S_DONE
  } state_t;

  // Counts are rebased to 1601-01-01, the start of a 400-year cycle
  localparam int EPOCH_OFFSET = 134774;  // days from 1601-01-01 to 1970-01-01
  localparam int YEAR_BASE    = 1601;
  localparam int EPOCH_YEAR   = 1970;

  // Chunk lengths in days
  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_1Y   = 365;

  // Year increments per chunk
  localparam int YEARS_400 = 400;
  localparam int YEARS_100 = 100;
  localparam int YEARS_4   = 4;
  localparam int YEARS_1   = 1;

  // Most chunks of each size taken before stepping down
  localparam int C100_MAX   = 3;
  localparam int C4_MAX     = 24;
  localparam int Y1_MAX     = 3;
  localparam int MONTH_LAST = 11;

  // Month length, months numbered from 0 for January
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/dcc_addsub.sv =====
// ----------------------------------------------------------------------------
// dcc_addsub: shared add / compare-subtract unit
// With sub high gives a - b and carry high when a >= b; otherwise a + b.
// ----------------------------------------------------------------------------
module dcc_addsub #(
  parameter int WIDTH = 19
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] res,
  output logic             carry
);

  logic [WIDTH:0] sum;

  // Two's complement subtract via inverted operand and carry in
  assign sum   = {1'b0, a} + {1'b0, (b ^ {WIDTH{sub}})} + {{WIDTH{1'b0}}, sub};
  assign res   = sum[WIDTH-1:0];
  assign carry = sum[WIDTH];

endmodule

// ===== hw/rtl/day_count_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// day_count_to_calendar_date: days since 1970-01-01 to Gregorian date
// Converts a signed day count into year, month and day of month.
// ----------------------------------------------------------------------------
// One word is converted at a time: in_ready is high only while the block is
// idle. After acceptance the count is rebased to 1601-01-01, whole 400-year
// cycles are removed by shift-and-subtract, then up to 3 centuries, 24
// four-year groups and 3 single years are stepped off, up to 11 whole months
// are stepped off, and the done state hands the word to the output register.
// Every step goes through one shared add/subtract unit. A negative count goes
// straight to the done state and returns 1970-01-01 with error set. The output
// register holds a result until taken while the next word is accepted; a
// result still waiting there holds the next word in the done state until it
// is taken.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date #(
  parameter int DAY_COUNT_BITS = 21
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [DAY_COUNT_BITS-1:0] day_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [12:0]               year,
  output logic [3:0]                month,
  output logic [4:0]                day_of_month,
  output logic                      error
);

  // Working width: holds the rebased count
  localparam int NW = ((DAY_COUNT_BITS - 1 > 18) ? DAY_COUNT_BITS - 1 : 18) + 1;
  // Quotient bits of the 400-year division
  localparam int QB = NW - 17;

  dcc_pkg::state_t state, state_next;

  logic [NW-1:0] n;
  logic [12:0]   yacc;
  logic [4:0]    cnt;
  logic [1:0]    c100;
  logic          c4_full;
  logic          leap;
  logic          err;

  logic [NW-1:0] op_b;
  logic          op_sub;
  logic [NW-1:0] unit_res;
  logic          unit_carry;

  logic          in_fire;
  logic          load_out;
  logic          take;

  assign in_ready = (state == dcc_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_out = (state == dcc_pkg::S_DONE) && (!out_valid || out_ready);

  // Shared arithmetic unit
  dcc_addsub #(.WIDTH(NW)) u_unit (
    .a     (n),
    .b     (op_b),
    .sub   (op_sub),
    .res   (unit_res),
    .carry (unit_carry)
  );

  // Chunk step is taken when it fits and the count limit is not reached
  always_comb begin
    case (state)
      dcc_pkg::S_C100: take = unit_carry && (cnt != 5'(dcc_pkg::C100_MAX));
      dcc_pkg::S_C4:   take = unit_carry && (cnt != 5'(dcc_pkg::C4_MAX));
      dcc_pkg::S_Y1:   take = unit_carry && (cnt != 5'(dcc_pkg::Y1_MAX));
      dcc_pkg::S_MON:  take = unit_carry && (cnt != 5'(dcc_pkg::MONTH_LAST));
      default:         take = unit_carry;
    endcase
  end

  // Operand selection for the shared unit
  always_comb begin
    op_sub = 1'b1;
    case (state)
      dcc_pkg::S_OFFS: begin
        op_b   = NW'(dcc_pkg::EPOCH_OFFSET);
        op_sub = 1'b0;
      end
      dcc_pkg::S_DIV:  op_b = NW'(dcc_pkg::DAYS_400Y) << cnt;
      dcc_pkg::S_C100: op_b = NW'(dcc_pkg::DAYS_100Y);
      dcc_pkg::S_C4:   op_b = NW'(dcc_pkg::DAYS_4Y);
      dcc_pkg::S_Y1:   op_b = NW'(dcc_pkg::DAYS_1Y);
      dcc_pkg::S_MON:  op_b = NW'(dcc_pkg::month_days(cnt[3:0], leap));
      default:         op_b = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dcc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = day_count[DAY_COUNT_BITS-1] ? dcc_pkg::S_DONE : dcc_pkg::S_OFFS;
        end
      end
      dcc_pkg::S_OFFS: state_next = dcc_pkg::S_DIV;
      dcc_pkg::S_DIV: begin
        if (cnt == 5'd0) state_next = dcc_pkg::S_C100;
      end
      dcc_pkg::S_C100: if (!take) state_next = dcc_pkg::S_C4;
      dcc_pkg::S_C4:   if (!take) state_next = dcc_pkg::S_Y1;
      dcc_pkg::S_Y1:   if (!take) state_next = dcc_pkg::S_MON;
      dcc_pkg::S_MON:  if (!take) state_next = dcc_pkg::S_DONE;
      dcc_pkg::S_DONE: if (load_out) state_next = dcc_pkg::S_IDLE;
      default:         state_next = dcc_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dcc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      dcc_pkg::S_IDLE: begin
        if (in_fire) begin
          n    <= {{(NW - DAY_COUNT_BITS + 1){1'b0}}, day_count[DAY_COUNT_BITS-2:0]};
          err  <= day_count[DAY_COUNT_BITS-1];
          yacc <= 13'(dcc_pkg::YEAR_BASE);
          cnt  <= '0;
        end
      end
      dcc_pkg::S_OFFS: begin
        n   <= unit_res;
        cnt <= 5'(QB - 1);
      end
      dcc_pkg::S_DIV: begin
        if (unit_carry) begin
          n    <= unit_res;
          yacc <= yacc + (13'(dcc_pkg::YEARS_400) << cnt);
        end
        if (cnt != 5'd0) cnt <= cnt - 5'd1;
      end
      dcc_pkg::S_C100: begin
        if (take) begin
          n    <= unit_res;
          yacc <= yacc + 13'(dcc_pkg::YEARS_100);
          cnt  <= cnt + 5'd1;
        end else begin
          c100 <= cnt[1:0];
          cnt  <= '0;
        end
      end
      dcc_pkg::S_C4: begin
        if (take) begin
          n    <= unit_res;
          yacc <= yacc + 13'(dcc_pkg::YEARS_4);
          cnt  <= cnt + 5'd1;
        end else begin
          c4_full <= (cnt == 5'(dcc_pkg::C4_MAX));
          cnt     <= '0;
        end
      end
      dcc_pkg::S_Y1: begin
        if (take) begin
          n    <= unit_res;
          yacc <= yacc + 13'(dcc_pkg::YEARS_1);
          cnt  <= cnt + 5'd1;
        end else begin
          // last year of a four-year group; century years only every 400
          leap <= (cnt == 5'(dcc_pkg::Y1_MAX)) &&
                  (!c4_full || (c100 == 2'(dcc_pkg::C100_MAX)));
          cnt  <= '0;
        end
      end
      dcc_pkg::S_MON: begin
        if (take) begin
          n   <= unit_res;
          cnt <= cnt + 5'd1;
        end
      end
      dcc_pkg::S_DONE: begin
        if (load_out) begin
          error <= err;
          if (err) begin
            year         <= 13'(dcc_pkg::EPOCH_YEAR);
            month        <= 4'd1;
            day_of_month <= 5'd1;
          end else begin
            year         <= yacc;
            month        <= cnt[3:0] + 4'd1;
            day_of_month <= n[4:0] + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_err_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (year == 13'(dcc_pkg::EPOCH_YEAR) && month == 4'd1 &&
                              day_of_month == 5'd1))
    else $error("error word without epoch date");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !error) |-> (month >= 4'd1 && month <= 4'd12 &&
                               day_of_month >= 5'd1 && day_of_month <= 5'd31 &&
                               year >= 13'(dcc_pkg::EPOCH_YEAR)))
    else $error("converted date out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("accepted a word while busy");

  a_month_count: assert property (@(posedge clk) disable iff (rst)
    (state == dcc_pkg::S_MON) |-> (cnt <= 5'(dcc_pkg::MONTH_LAST)))
    else $error("month counter overran");

  a_group_count: assert property (@(posedge clk) disable iff (rst)
    (state == dcc_pkg::S_C4) |-> (cnt <= 5'(dcc_pkg::C4_MAX)))
    else $error("four-year group counter overran");

endmodule
